// ===== rtl/qte_pkg.sv =====
// Shared constants, types and tables of the quaternion to XYZ Euler angle converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package qte_pkg;

	// Input and output formats.
	localparam int QUAT_WIDTH      = 16;
	localparam int ANGLE_FRAC_BITS = 13;

	// Inputs wider than thirty bits are floored to thirty significant bits.
	localparam int WORK_WIDTH = (QUAT_WIDTH > 30) ? 30 : QUAT_WIDTH;
	localparam int WORK_FRAC  = WORK_WIDTH - 1;
	localparam int QSHIFT     = QUAT_WIDTH - WORK_WIDTH;

	// Angle accumulator and CORDIC length.
	localparam int ZFRAC        = 30;
	localparam int CORDIC_STEPS = 30;

	// Product and sum widths.
	localparam int PW = 2 * WORK_WIDTH;
	localparam int SW = PW + 2;

	// Operand width of the arctangent units.
	localparam int OPW = (SW > ZFRAC + 2) ? SW : ZFRAC + 2;

	// Scaling of the sine to thirty fractional bits.
	localparam int SDN = (2 * WORK_FRAC >= ZFRAC) ? 2 * WORK_FRAC - ZFRAC : 0;
	localparam int SUP = (2 * WORK_FRAC >= ZFRAC) ? 0 : ZFRAC - 2 * WORK_FRAC;

	// Square root of the cosine term.
	localparam int MAGW       = ZFRAC + 1;
	localparam int RW         = 2 * ZFRAC + 1;
	localparam int SQRT_STEPS = ZFRAC + 1;

	// CORDIC datapath width and operand normalisation.
	localparam int CW     = ZFRAC + 3;
	localparam int RSTEPS = $clog2(OPW - ZFRAC + 1);
	localparam int LSTEPS = 5;

	// Latency of one arctangent unit: three normalisation stages, the CORDIC
	// stages and the quadrant correction.
	localparam int ATAN_LAT = 4 + CORDIC_STEPS;

	// Output rounding.
	localparam int RND_SH = ZFRAC - ANGLE_FRAC_BITS;
	localparam int AXW    = ANGLE_FRAC_BITS + 3;
	localparam int AYW    = ANGLE_FRAC_BITS + 2;

	typedef logic signed [OPW-1:0] opnd_t;
	typedef logic signed [CW-1:0]  cval_t;

	localparam cval_t PI_Z      = cval_t'(64'd3373259426);
	localparam cval_t HALF_PI_Z = cval_t'(64'd1686629713);

	// atan(2^-i) scaled by 2^30, truncated, except that the last three entries are rounded up.
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
		32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
		32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
		32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
		32'd31,        32'd15,        32'd8,         32'd4,         32'd2
	};

endpackage

`default_nettype wire

// ===== rtl/qte_quat_if.sv =====
// Input channel of the converter: one quaternion per transfer.
// Depends on qte_pkg for the field width.
`default_nettype none

interface qte_quat_if;
	import qte_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [QUAT_WIDTH-1:0] q_w;
	logic signed [QUAT_WIDTH-1:0] q_x;
	logic signed [QUAT_WIDTH-1:0] q_y;
	logic signed [QUAT_WIDTH-1:0] q_z;

	modport source (output valid, q_w, q_x, q_y, q_z, input ready);
	modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/qte_euler_if.sv =====
// Output channel of the converter: three Euler angles and the clamp flag per transfer.
// Depends on qte_pkg for the field widths.
`default_nettype none

interface qte_euler_if;
	import qte_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [AXW-1:0] angle_x;
	logic signed [AYW-1:0] angle_y;
	logic signed [AXW-1:0] angle_z;
	logic                  sine_clamped;

	modport source (output valid, angle_x, angle_y, angle_z, sine_clamped, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, sine_clamped, output ready);
endinterface

`default_nettype wire

// ===== rtl/qte_atan2.sv =====
// Pipelined four-quadrant arctangent: operand normalisation, CORDIC vectoring, quadrant fix.
// Depends on qte_pkg; instantiated by quat_to_euler_xyz_converter.
`default_nettype none

module qte_atan2 (
	input  logic          clk,
	input  logic          en,
	input  qte_pkg::opnd_t num,
	input  qte_pkg::opnd_t den,
	output qte_pkg::cval_t angle
);
	import qte_pkg::*;

	localparam int LSPLIT = 3;

	typedef logic [OPW-1:0]   mag_t;
	typedef logic [ZFRAC-1:0] nrm_t;

	typedef struct packed {
		logic yzero;
		logic xzero;
		logic xneg;
		logic yneg;
	} quad_t;

	// Stage 1: magnitudes and right shift into thirty bits.
	mag_t  ax_c, ay_c, m1_c;
	quad_t qd_c;

	always_comb begin
		ax_c = den[OPW-1] ? mag_t'(-den) : mag_t'(den);
		ay_c = num[OPW-1] ? mag_t'(-num) : mag_t'(num);
		qd_c.yzero = (num == '0);
		qd_c.xzero = (den == '0);
		qd_c.xneg  = den[OPW-1];
		qd_c.yneg  = num[OPW-1];
		m1_c = (ax_c > ay_c) ? ax_c : ay_c;
		for (int k = RSTEPS - 1; k >= 0; k--) begin
			if (m1_c >= (mag_t'(1) << (ZFRAC + (1 << k) - 1))) begin
				ax_c = ax_c >> (1 << k);
				ay_c = ay_c >> (1 << k);
				m1_c = m1_c >> (1 << k);
			end
		end
	end

	nrm_t  ux_s1, uy_s1;
	quad_t qd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= ax_c[ZFRAC-1:0];
			uy_s1 <= ay_c[ZFRAC-1:0];
			qd_s1 <= qd_c;
		end
	end

	// Stage 2: coarse left shifts.
	nrm_t ux2_c, uy2_c, m2_c;

	always_comb begin
		ux2_c = ux_s1;
		uy2_c = uy_s1;
		m2_c  = (ux_s1 > uy_s1) ? ux_s1 : uy_s1;
		for (int k = LSTEPS - 1; k >= LSPLIT; k--) begin
			if (m2_c < (nrm_t'(1) << (ZFRAC - (1 << k)))) begin
				ux2_c = ux2_c << (1 << k);
				uy2_c = uy2_c << (1 << k);
				m2_c  = m2_c << (1 << k);
			end
		end
	end

	nrm_t  ux_s2, uy_s2;
	quad_t qd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s2 <= ux2_c;
			uy_s2 <= uy2_c;
			qd_s2 <= qd_s1;
		end
	end

	// Stage 3: fine left shifts, so that the larger operand lies in [2^29, 2^30).
	nrm_t ux3_c, uy3_c, m3_c;

	always_comb begin
		ux3_c = ux_s2;
		uy3_c = uy_s2;
		m3_c  = (ux_s2 > uy_s2) ? ux_s2 : uy_s2;
		for (int k = LSPLIT - 1; k >= 0; k--) begin
			if (m3_c < (nrm_t'(1) << (ZFRAC - (1 << k)))) begin
				ux3_c = ux3_c << (1 << k);
				uy3_c = uy3_c << (1 << k);
				m3_c  = m3_c << (1 << k);
			end
		end
	end

	cval_t cx_s [CORDIC_STEPS+1];
	cval_t cy_s [CORDIC_STEPS+1];
	cval_t z_s  [CORDIC_STEPS+1];
	quad_t qd_s [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= cval_t'(ux3_c);
			cy_s[0] <= cval_t'(uy3_c);
			z_s[0]  <= '0;
			qd_s[0] <= qd_s2;
		end
	end

	// CORDIC vectoring, one micro-rotation per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic rot_down;

		assign rot_down = !cy_s[i][CW-1] && (cy_s[i] != '0);

		always_ff @(posedge clk) begin
			if (en) begin
				if (rot_down) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					z_s[i+1]  <= z_s[i] + cval_t'(ATAN_TAB[i]);
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					z_s[i+1]  <= z_s[i] - cval_t'(ATAN_TAB[i]);
				end
				qd_s[i+1] <= qd_s[i];
			end
		end
	end

	// Quadrant correction and the cases with a zero operand.
	cval_t zc_c;
	quad_t qf;

	always_comb begin
		qf   = qd_s[CORDIC_STEPS];
		zc_c = qf.xneg ? (PI_Z - z_s[CORDIC_STEPS]) : z_s[CORDIC_STEPS];
		if (qf.yneg) begin
			zc_c = -zc_c;
		end
		priority if (qf.yzero) begin
			zc_c = qf.xneg ? PI_Z : '0;
		end else if (qf.xzero) begin
			zc_c = qf.yneg ? -HALF_PI_Z : HALF_PI_Z;
		end else begin
			zc_c = zc_c;
		end
	end

	cval_t angle_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s4 <= zc_c;
		end
	end

	assign angle = angle_s4;

endmodule

`default_nettype wire

// ===== rtl/quat_to_euler_xyz_converter.sv =====
// Top level of the quaternion to XYZ Euler angle converter.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and qte_atan2.
`default_nettype none

// The converter takes one quaternion per transfer on quat and returns, for
// each, one transfer on euler holding angle_x and angle_z in signed Q3.13
// radians, angle_y in signed Q2.13 radians and sine_clamped, which is set
// when the arcsine argument 2(xz + wy) lay beyond plus or minus one and was
// saturated. A new quaternion is accepted in every cycle in which the
// pipeline is not held, and results leave in the order the quaternions came
// in. On its way to euler a quaternion passes a register for the ten
// products, one for the sums and the saturation, one for the square of the
// sine, one for the radicand, the stages of the digit-by-digit square root
// that yields the cosine, the three parallel arctangent units (normalisation,
// 30 CORDIC stages, quadrant correction) and the output register. The whole
// pipeline advances together; it holds only when a finished result sits in
// the output register unclaimed and the last pipeline stage also carries a
// result, so empty stages are squeezed out while the output side stalls.
// There is no state beyond the pipeline and no clearing pass after reset.

module quat_to_euler_xyz_converter (
	input  logic        clk,
	input  logic        arst_n,
	qte_quat_if.sink    quat,
	qte_euler_if.source euler
);
	import qte_pkg::*;

	localparam int DEPTH = 4 + SQRT_STEPS + ATAN_LAT;
	localparam int SLEN  = SQRT_STEPS + 2;

	localparam cval_t RND_HALF = cval_t'(1) <<< (RND_SH - 1);
	localparam logic signed [AXW-1:0] ANG_MAX = AXW'((PI_Z + RND_HALF) >>> RND_SH);
	localparam logic signed [AYW-1:0] Y_EDGE  = AYW'((HALF_PI_Z + RND_HALF) >>> RND_SH);

	typedef logic signed [WORK_WIDTH-1:0] work_t;
	typedef logic signed [PW-1:0]         prod_t;
	typedef logic signed [SW-1:0]         sum_t;

	typedef struct packed {
		opnd_t axn;
		opnd_t axd;
		opnd_t azn;
		opnd_t azd;
		opnd_t s30;
		logic  clamp;
	} side_t;

	function automatic cval_t rnd(input cval_t z);
		return (z + RND_HALF) >>> RND_SH;
	endfunction

	// Pipeline control. The output register takes a new result when it is
	// empty or its result is being transferred; the pipeline moves when its
	// last stage is empty or can hand over.
	logic             en;
	logic             out_load;
	logic [DEPTH-1:0] v_s;
	logic             valid_q;

	assign out_load   = !valid_q || euler.ready;
	assign en         = !v_s[DEPTH-1] || out_load;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DEPTH-2:0], quat.valid};
		end
	end

	// Stage 1: the ten products of the quaternion components.
	work_t w_c, x_c, y_c, z_c;

	assign w_c = work_t'(quat.q_w >>> QSHIFT);
	assign x_c = work_t'(quat.q_x >>> QSHIFT);
	assign y_c = work_t'(quat.q_y >>> QSHIFT);
	assign z_c = work_t'(quat.q_z >>> QSHIFT);

	prod_t ww_s1, xx_s1, yy_s1, zz_s1;
	prod_t wx_s1, yz_s1, wz_s1, xy_s1, xz_s1, wy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= w_c * w_c;
			xx_s1 <= x_c * x_c;
			yy_s1 <= y_c * y_c;
			zz_s1 <= z_c * z_c;
			wx_s1 <= w_c * x_c;
			yz_s1 <= y_c * z_c;
			wz_s1 <= w_c * z_c;
			xy_s1 <= x_c * y_c;
			xz_s1 <= x_c * z_c;
			wy_s1 <= w_c * y_c;
		end
	end

	// Stage 2: arctangent operands, and the sine saturated to plus or minus
	// one and brought to thirty fractional bits.
	localparam sum_t ONE = sum_t'(1) <<< (2 * WORK_FRAC);

	sum_t  s_c, s_sat_c;
	side_t side_c;

	always_comb begin
		s_c          = (sum_t'(xz_s1) + sum_t'(wy_s1)) <<< 1;
		side_c.clamp = 1'b0;
		s_sat_c      = s_c;
		if (s_c > ONE) begin
			s_sat_c      = ONE;
			side_c.clamp = 1'b1;
		end
		if (s_c < -ONE) begin
			s_sat_c      = -ONE;
			side_c.clamp = 1'b1;
		end
		side_c.s30 = opnd_t'(s_sat_c >>> SDN) <<< SUP;
		side_c.axn = opnd_t'((sum_t'(wx_s1) - sum_t'(yz_s1)) <<< 1);
		side_c.axd = opnd_t'(sum_t'(ww_s1) - sum_t'(xx_s1) - sum_t'(yy_s1) + sum_t'(zz_s1));
		side_c.azn = opnd_t'((sum_t'(wz_s1) - sum_t'(xy_s1)) <<< 1);
		side_c.azd = opnd_t'(sum_t'(ww_s1) + sum_t'(xx_s1) - sum_t'(yy_s1) - sum_t'(zz_s1));
	end

	side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c;
		end
	end

	// Stage 3: square of the sine magnitude.
	logic [MAGW-1:0]   mag_c;
	logic [2*MAGW-1:0] sq_c;

	assign mag_c = side_s2.s30[OPW-1] ? MAGW'(-side_s2.s30) : MAGW'(side_s2.s30);
	assign sq_c  = mag_c * mag_c;

	logic [RW-1:0] sq_s3;
	side_t         side_s [SLEN];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3     <= RW'(sq_c);
			side_s[0] <= side_s2;
		end
	end

	// Stage 4: radicand 2^60 - s^2, then the square root one result bit per stage.
	logic [RW-1:0] rem_s  [SQRT_STEPS+1];
	logic [RW-1:0] root_s [SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= (RW'(1) << (2 * ZFRAC)) - sq_s3;
			root_s[0] <= '0;
			side_s[1] <= side_s[0];
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [RW:0] BITV = (RW + 1)'(1) << (2 * ZFRAC - 2 * k);

		logic [RW:0] trial;

		assign trial = {1'b0, root_s[k]} + BITV;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[k]} >= trial) begin
					rem_s[k+1]  <= rem_s[k] - RW'(trial);
					root_s[k+1] <= (root_s[k] >> 1) + RW'(BITV);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
				side_s[k+2] <= side_s[k+1];
			end
		end
	end

	// Three arctangent units in parallel.
	opnd_t cos_c;
	cval_t ax_z, ay_z, az_z;

	assign cos_c = opnd_t'(root_s[SQRT_STEPS][ZFRAC:0]);

	qte_atan2 u_atan_x (
		.clk   (clk),
		.en    (en),
		.num   (side_s[SLEN-1].axn),
		.den   (side_s[SLEN-1].axd),
		.angle (ax_z)
	);

	qte_atan2 u_atan_y (
		.clk   (clk),
		.en    (en),
		.num   (side_s[SLEN-1].s30),
		.den   (cos_c),
		.angle (ay_z)
	);

	qte_atan2 u_atan_z (
		.clk   (clk),
		.en    (en),
		.num   (side_s[SLEN-1].azn),
		.den   (side_s[SLEN-1].azd),
		.angle (az_z)
	);

	// The clamp flag travels alongside the arctangent units.
	logic [ATAN_LAT-1:0] clamp_s;

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s <= {clamp_s[ATAN_LAT-2:0], side_s[SLEN-1].clamp};
		end
	end

	// Output register: rounding to the output format.
	cval_t rx_c, ry_c, rz_c;

	assign rx_c = rnd(ax_z);
	assign ry_c = rnd(ay_z);
	assign rz_c = rnd(az_z);

	logic signed [AXW-1:0] angle_x_q;
	logic signed [AYW-1:0] angle_y_q;
	logic signed [AXW-1:0] angle_z_q;
	logic                  clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= v_s[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			angle_x_q <= AXW'(rx_c);
			angle_y_q <= AYW'(ry_c);
			angle_z_q <= AXW'(rz_c);
			clamp_q   <= clamp_s[ATAN_LAT-1];
		end
	end

	assign euler.valid        = valid_q;
	assign euler.angle_x      = angle_x_q;
	assign euler.angle_y      = angle_y_q;
	assign euler.angle_z      = angle_z_q;
	assign euler.sine_clamped = clamp_q;

	// A saturated sine always gives a pitch of plus or minus a quarter turn.
	a_clamp_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && euler.sine_clamped |->
			(euler.angle_y == Y_EDGE || euler.angle_y == -Y_EDGE))
		else $error("clamped sine without a quarter-turn pitch");

	// While the pipeline holds, no valid bit moves, appears or vanishes.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_s == $past(v_s)))
		else $error("pipeline valid bits changed during a hold");

	// Roll and yaw stay within one half turn.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid |-> (euler.angle_x <= ANG_MAX && euler.angle_x >= -ANG_MAX &&
			euler.angle_z <= ANG_MAX && euler.angle_z >= -ANG_MAX))
		else $error("roll or yaw beyond a half turn");

endmodule

`default_nettype wire

// ===== bench/quat_to_euler_xyz_converter_test.sv =====
// Self-checking bench for the quaternion to XYZ Euler angle converter.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and the converter top level.
`timescale 1ns / 1ps

module quat_to_euler_xyz_converter_test;
	import qte_pkg::*;

	localparam longint PI_ANG      = 64'sd3373259426;
	localparam longint HALF_PI_ANG = 64'sd1686629713;
	localparam int     N_RANDOM    = 1230;
	localparam int     CYCLE_LIMIT = 400000;
	// The drain wait allows for the depth of the pipeline and more.
	localparam int     DRAIN_CYCLES = 150;

	typedef struct packed {
		logic signed [AXW-1:0] ax;
		logic signed [AYW-1:0] ay;
		logic signed [AXW-1:0] az;
		logic                  clamped;
	} euler_t;

	// Arctangent table scaled by 2^30, as the converter holds it.
	localparam longint ARC_TAB [30] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515,  16775850,  8388437,   4194282,   2097149,
		1048575,   524287,    262143,    131071,    65535,
		32767,     16383,     8191,      4095,      2047,
		1023,      511,       255,       127,       63,
		31,        15,        8,         4,         2
	};

	// Works out the expected angles of every accepted quaternion and checks the
	// results against them in order.
	class euler_scoreboard;
		euler_t awaited[$];
		int     mismatches;

		function new();
			awaited    = {};
			mismatches = 0;
		endfunction

		static function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Vectoring CORDIC with the operands normalised to [2^29, 2^30).
		static function longint arctan2(longint num, longint den);
			longint unsigned ux, uy, m;
			longint cx, cy, ang, dx, dy;
			if (num == 0)
				return (den >= 0) ? 0 : PI_ANG;
			if (den == 0)
				return (num > 0) ? HALF_PI_ANG : -HALF_PI_ANG;
			ux = (den < 0) ? -den : den;
			uy = (num < 0) ? -num : num;
			m  = (ux > uy) ? ux : uy;
			while (m >= (64'd1 << 30)) begin
				ux >>= 1; uy >>= 1; m >>= 1;
			end
			while (m < (64'd1 << 29)) begin
				ux <<= 1; uy <<= 1; m <<= 1;
			end
			cx  = longint'(ux);
			cy  = longint'(uy);
			ang = 0;
			for (int i = 0; i < 30; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy > 0) begin
					cx += dx; cy -= dy; ang += ARC_TAB[i];
				end else begin
					cx -= dx; cy += dy; ang -= ARC_TAB[i];
				end
			end
			if (den < 0)
				ang = PI_ANG - ang;
			if (num < 0)
				ang = -ang;
			return ang;
		endfunction

		// Round half up from 30 fractional bits to the output format.
		static function longint to_angle(longint ang);
			return (ang + (64'sd1 << (RND_SH - 1))) >>> RND_SH;
		endfunction

		function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
				logic signed [15:0] qy, logic signed [15:0] qz);
			longint w, x, y, z, sn, unit;
			longint unsigned cs;
			euler_t e;
			w = qw; x = qx; y = qy; z = qz;
			unit = 64'sd1 << (2 * WORK_FRAC);
			e.ax = AXW'(to_angle(arctan2(2 * (w * x - y * z), w*w - x*x - y*y + z*z)));
			e.az = AXW'(to_angle(arctan2(2 * (w * z - x * y), w*w + x*x - y*y - z*z)));
			sn = 2 * (x * z + w * y);
			e.clamped = 1'b0;
			if (sn > unit) begin
				sn = unit; e.clamped = 1'b1;
			end
			if (sn < -unit) begin
				sn = -unit; e.clamped = 1'b1;
			end
			// With sixteen-bit inputs the sine already has thirty fractional bits.
			cs = int_sqrt((64'd1 << 60) - longint'(sn * sn));
			e.ay = AYW'(to_angle(arctan2(sn, longint'(cs))));
			awaited.push_back(e);
		endfunction

		function void check_result(euler_t got);
			euler_t e;
			if (awaited.size() == 0) begin
				$display("%0t: result with nothing awaited: ax %0d ay %0d az %0d clamp %0b",
					$time, got.ax, got.ay, got.az, got.clamped);
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			if (got.ax !== e.ax) begin
				$display("%0t: angle_x expected %0d actual %0d", $time, e.ax, got.ax);
				mismatches++;
			end
			if (got.ay !== e.ay) begin
				$display("%0t: angle_y expected %0d actual %0d", $time, e.ay, got.ay);
				mismatches++;
			end
			if (got.az !== e.az) begin
				$display("%0t: angle_z expected %0d actual %0d", $time, e.az, got.az);
				mismatches++;
			end
			if (got.clamped !== e.clamped) begin
				$display("%0t: sine_clamped expected %0b actual %0b", $time,
					e.clamped, got.clamped);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle;
	int   sent;

	qte_quat_if  quat ();
	qte_euler_if euler ();

	quat_to_euler_xyz_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.quat   (quat.sink),
		.euler  (euler.source)
	);

	euler_scoreboard sb = new();

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		cycle <= cycle + 1;

	// Ready on the result side: random back-pressure with a chance of about thirteen
	// in a hundred, a quiet stretch with none at all, and one long hold-off that
	// lets the pipeline fill so that the input side has to stall.
	int hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler.ready <= 1'b0;
			hold_left   <= 0;
			hold_done   <= 1'b0;
		end else begin
			if (euler.valid && euler.ready)
				sb.check_result('{euler.angle_x, euler.angle_y, euler.angle_z,
					euler.sine_clamped});
			if (hold_left > 0) begin
				hold_left   <= hold_left - 1;
				euler.ready <= 1'b0;
			end else if (!hold_done && sent >= 700) begin
				hold_done   <= 1'b1;
				hold_left   <= 250;
				euler.ready <= 1'b0;
			end else if (sent >= 300 && sent < 550) begin
				euler.ready <= 1'b1;
			end else begin
				euler.ready <= ($urandom_range(99) >= 13);
			end
		end
	end

	// Offer one quaternion and hold it until the converter takes it. An idle
	// cycle may come first, except in the quiet stretch.
	task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		if (!(sent >= 300 && sent < 550) && $urandom_range(99) < 13) begin
			quat.valid <= 1'b0;
			@(posedge clk);
		end
		quat.valid <= 1'b1;
		quat.q_w   <= w;
		quat.q_x   <= x;
		quat.q_y   <= y;
		quat.q_z   <= z;
		do
			@(posedge clk);
		while (!quat.ready);
		sb.note_quat(w, x, y, z);
		sent++;
	endtask

	// A unit quaternion with random direction, scaled to Q1.15.
	task automatic send_unit_quat();
		real a, b, c, d, n;
		a = real'(int'($urandom_range(65535)) - 32768);
		b = real'(int'($urandom_range(65535)) - 32768);
		c = real'(int'($urandom_range(65535)) - 32768);
		d = real'(int'($urandom_range(65535)) - 32768);
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0)
			send_quat(16'sd32767, 0, 0, 0);
		else
			send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
				16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
	endtask

	initial begin
		int pick;
		int nz;
		arst_n     = 1'b0;
		cycle      = 0;
		sent       = 0;
		quat.valid = 1'b0;
		quat.q_w   = '0;
		quat.q_x   = '0;
		quat.q_y   = '0;
		quat.q_z   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the all-zero quaternion (atan2 of zero by zero), the
		// identity, extremes of every field, zero numerators with negative
		// denominators, zero denominators, gimbal lock and saturation of the sine.
		send_quat(0, 0, 0, 0);
		send_quat(16'sd32767, 0, 0, 0);
		send_quat(-16'sd32768, 0, 0, 0);
		send_quat(0, 16'sd32767, 0, 0);
		send_quat(0, 0, 16'sd32767, 0);
		send_quat(0, 0, 0, 16'sd32767);
		send_quat(0, -16'sd32768, 0, 0);
		send_quat(0, 0, -16'sd32768, 0);
		send_quat(0, 0, 0, -16'sd32768);
		send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
		send_quat(16'sd23170, 0, 16'sd23170, 0);
		send_quat(16'sd23170, 0, -16'sd23170, 0);
		send_quat(16'sd23171, 0, 16'sd23171, 0);
		send_quat(16'sd23171, 0, -16'sd23171, 0);
		send_quat(16'sd23170, 16'sd23170, 0, 0);
		send_quat(16'sd23170, 0, 0, 16'sd23170);
		send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
		send_quat(16'sd1, 0, 0, 0);
		send_quat(-16'sd1, 16'sd1, -16'sd1, 16'sd1);

		// Random part: mostly unit quaternions, some near gimbal lock, and raw
		// bit patterns that reach every bit and the saturated sine.
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_unit_quat();
			end else if (pick < 75) begin
				nz = $urandom_range(40);
				send_quat(16'(23170 + int'($urandom_range(2 * nz)) - nz),
					16'(int'($urandom_range(2 * nz)) - nz),
					16'(($urandom_range(1) ? 23170 : -23170)
						+ int'($urandom_range(2 * nz)) - nz),
					16'(int'($urandom_range(2 * nz)) - nz));
			end else begin
				send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
		quat.valid <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		wait (cycle >= CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
